// ----- rtl/core/arf_pkg.sv -----
package arf_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int ENV_W      = 31;
	localparam int COEFF_W    = 16;
	localparam int MODE_W     = 2;
	localparam int MAG_W      = SAMPLE_W + 1;
	localparam int PROD_W     = MAG_W + ENV_W;
	localparam int FRAC_SHIFT = 15;
	localparam int RAD_W      = 2 * ENV_W;
	localparam int REM_W      = ENV_W + 2;
	localparam int SQRT_STEPS = ENV_W;
	localparam int CNT_W      = 5;
	localparam int ADDR_W     = 4;
	localparam int DATA_W     = 32;

	localparam logic [MODE_W-1:0] MODE_ABS = 2'd0;
	localparam logic [MODE_W-1:0] MODE_PWR = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RMS = 2'd2;

	localparam logic [1:0] REG_MODE    = 2'd0;
	localparam logic [1:0] REG_ATTACK  = 2'd1;
	localparam logic [1:0] REG_RELEASE = 2'd2;

	localparam logic [MODE_W-1:0]  MODE_RST    = MODE_ABS;
	localparam logic [COEFF_W-1:0] ATTACK_RST  = 16'd65387;
	localparam logic [COEFF_W-1:0] RELEASE_RST = 16'd65506;

	typedef struct packed {
		logic level;
		logic mul1;
		logic mul2;
		logic upd;
		logic sqrt_step;
		logic out_load;
	} arf_cmd_t;

	typedef struct packed {
		logic sqrt_last;
	} arf_status_t;

endpackage

// ----- rtl/core/arf_sample_if.sv -----
interface arf_sample_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [arf_pkg::SAMPLE_W-1:0]  sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

// ----- rtl/core/arf_env_if.sv -----
interface arf_env_if;
	logic                        valid;
	logic                        ready;
	logic [arf_pkg::ENV_W-1:0]   envelope_out;

	modport source (output valid, output envelope_out, input ready);
	modport sink (input valid, input envelope_out, output ready);
endinterface

// ----- rtl/core/arf_ctrl.sv -----
module arf_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	output logic                          out_valid,
	input  logic                          out_ready,
	input  logic [arf_pkg::MODE_W-1:0]    mode,
	input  arf_pkg::arf_status_t          status,
	output arf_pkg::arf_cmd_t             cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LEVEL = 3'd1;
	localparam logic [2:0] ST_MUL1  = 3'd2;
	localparam logic [2:0] ST_MUL2  = 3'd3;
	localparam logic [2:0] ST_UPD   = 3'd4;
	localparam logic [2:0] ST_SQRT  = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_LEVEL;
			end
			ST_LEVEL: begin
				cmd.level = 1'b1;
				state_d   = ST_MUL1;
			end
			ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = ST_UPD;
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				state_d = (mode == arf_pkg::MODE_RMS) ? ST_SQRT : ST_DONE;
			end
			ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (status.sqrt_last) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

// ----- rtl/core/arf_dp.sv -----
module arf_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                load,
	input  logic signed [arf_pkg::SAMPLE_W-1:0] sample_in,
	input  logic [arf_pkg::MODE_W-1:0]          mode,
	input  logic [arf_pkg::COEFF_W-1:0]         attack_coeff,
	input  logic [arf_pkg::COEFF_W-1:0]         release_coeff,
	input  arf_pkg::arf_cmd_t                   cmd,
	output arf_pkg::arf_status_t                status,
	output logic [arf_pkg::ENV_W-1:0]           envelope_out
);

	localparam int MAG_W  = arf_pkg::MAG_W;
	localparam int ENV_W  = arf_pkg::ENV_W;
	localparam int PROD_W = arf_pkg::PROD_W;
	localparam int RAD_W  = arf_pkg::RAD_W;
	localparam int REM_W  = arf_pkg::REM_W;
	localparam int CNT_W  = arf_pkg::CNT_W;
	localparam int COEFF_W = arf_pkg::COEFF_W;

	logic [arf_pkg::SAMPLE_W-1:0] sample_q;
	logic [ENV_W-1:0]             level_q;
	logic [ENV_W-1:0]             env_q;
	logic [PROD_W-1:0]            prod_q;
	logic [RAD_W-1:0]             rad_q;
	logic [REM_W-1:0]             rem_q;
	logic [ENV_W-1:0]             root_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [ENV_W-1:0]             out_q;

	logic [MAG_W-1:0]   mag;
	logic [COEFF_W-1:0] coeff;
	logic [MAG_W-1:0]   mul_a;
	logic [ENV_W-1:0]   mul_b;
	logic [PROD_W-1:0]  mul_p;
	logic [REM_W+1:0]   rem_sh;
	logic [REM_W+1:0]   trial;
	logic               fits;

	assign mag = sample_q[arf_pkg::SAMPLE_W-1]
		? MAG_W'({1'b1, {(MAG_W-1){1'b0}}} - {1'b0, sample_q})
		: {1'b0, sample_q};

	assign coeff = (env_q < level_q) ? attack_coeff : release_coeff;

	always_comb begin
		mul_a = mag;
		mul_b = ENV_W'(mag);
		if (cmd.mul1) begin
			mul_a = MAG_W'({1'b1, {COEFF_W{1'b0}}} - {1'b0, coeff});
			mul_b = level_q;
		end else if (cmd.mul2) begin
			mul_a = {1'b0, coeff};
			mul_b = env_q;
		end
	end

	assign mul_p = {{ENV_W{1'b0}}, mul_a} * {{MAG_W{1'b0}}, mul_b};

	assign rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign fits   = (rem_sh >= trial);

	assign status.sqrt_last = (cnt_q == CNT_W'(arf_pkg::SQRT_STEPS - 1));
	assign envelope_out     = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_q <= '0;
		end else if (cmd.upd) begin
			env_q <= prod_q[COEFF_W + ENV_W - 1:COEFF_W];
		end
	end

	always_ff @(posedge clk) begin
		if (load) sample_q <= sample_in;
		if (cmd.level) begin
			if (mode == arf_pkg::MODE_ABS) level_q <= ENV_W'(mag) << arf_pkg::FRAC_SHIFT;
			else level_q <= mul_p[ENV_W-1:0];
		end
		if (cmd.mul1) prod_q <= mul_p;
		if (cmd.mul2) prod_q <= prod_q + mul_p;
		if (cmd.upd) begin
			rad_q  <= {1'b0, prod_q[COEFF_W + ENV_W - 1:COEFF_W],
				{(RAD_W-ENV_W-1){1'b0}}};
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= '0;
		end else if (cmd.sqrt_step) begin
			rad_q  <= rad_q << 2;
			rem_q  <= fits ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
			root_q <= {root_q[ENV_W-2:0], fits};
			cnt_q  <= cnt_q + 1'b1;
		end
		if (cmd.out_load) out_q <= (mode == arf_pkg::MODE_RMS) ? root_q : env_q;
	end

endmodule

// ----- rtl/core/attack_release_envelope_follower.sv -----
// Attack/release envelope follower.
// sample (sink): one signed Q1.15 audio sample per beat, valid/ready handshake.
// envelope (source): one unsigned Q1.30 envelope per input beat, in order.
// APB port sets rectify_mode (0x0), attack_coeff (0x4) and release_coeff (0x8);
// write only while the block is idle. pready is tied high; reads return values.
// Each sample is rectified (absolute value or square), smoothed by a one-pole
// filter whose coefficient depends on whether the level rises, and in RMS mode
// passed through a square root.
// Each sample steps through the LEVEL, MUL1, MUL2 and UPD states to DONE; in
// mode 2 a 2-bit-per-cycle square root runs 31 steps between UPD and DONE.
// A new sample is taken only in the idle state, once the last is done; the shared
// 17x31 multiplier forms the level (not in mode 0) and both filter products.
// A finished envelope sits in an output register; a stalled receiver does not
// block the next sample, which is processed and then held until the register
// frees. Reset clears the envelope to zero and restores the register defaults.
module attack_release_envelope_follower (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [arf_pkg::ADDR_W-1:0]     paddr,
	input  logic [arf_pkg::DATA_W-1:0]     pwdata,
	output logic [arf_pkg::DATA_W-1:0]     prdata,
	output logic                           pready,
	arf_sample_if.sink                     sample,
	arf_env_if.source                      envelope
);

	logic [arf_pkg::MODE_W-1:0]  mode_q;
	logic [arf_pkg::COEFF_W-1:0] attack_q;
	logic [arf_pkg::COEFF_W-1:0] release_q;
	logic [1:0]                  reg_idx;
	logic                        wr_en;
	logic                        in_ready;
	arf_pkg::arf_cmd_t           cmd;
	arf_pkg::arf_status_t        status;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= arf_pkg::MODE_RST;
			attack_q  <= arf_pkg::ATTACK_RST;
			release_q <= arf_pkg::RELEASE_RST;
		end else if (wr_en) begin
			case (reg_idx)
				arf_pkg::REG_MODE:    mode_q    <= pwdata[arf_pkg::MODE_W-1:0];
				arf_pkg::REG_ATTACK:  attack_q  <= pwdata[arf_pkg::COEFF_W-1:0];
				arf_pkg::REG_RELEASE: release_q <= pwdata[arf_pkg::COEFF_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			arf_pkg::REG_MODE:    prdata = arf_pkg::DATA_W'(mode_q);
			arf_pkg::REG_ATTACK:  prdata = arf_pkg::DATA_W'(attack_q);
			arf_pkg::REG_RELEASE: prdata = arf_pkg::DATA_W'(release_q);
			default:              prdata = '0;
		endcase
	end

	assign sample.ready = in_ready;

	arf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (in_ready),
		.out_valid (envelope.valid),
		.out_ready (envelope.ready),
		.mode      (mode_q),
		.status    (status),
		.cmd       (cmd)
	);

	arf_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (sample.valid && in_ready),
		.sample_in     (sample.sample_in),
		.mode          (mode_q),
		.attack_coeff  (attack_q),
		.release_coeff (release_q),
		.cmd           (cmd),
		.status        (status),
		.envelope_out  (envelope.envelope_out)
	);

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps

module tb;
	import arf_pkg::*;

	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

	typedef struct {
		bit                         set;
		logic [MODE_W-1:0]          mode;
		logic [COEFF_W-1:0]         att;
		logic [COEFF_W-1:0]         rel;
		logic signed [SAMPLE_W-1:0] smp;
		bit                         known;
		logic [ENV_W-1:0]           env;
	} stim_row_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	arf_sample_if sample_ch();
	arf_env_if    env_ch();

	attack_release_envelope_follower dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.sample   (sample_ch),
		.envelope (env_ch)
	);

	logic [MODE_W-1:0]  cfg_mode    = MODE_RST;
	logic [COEFF_W-1:0] cfg_attack  = ATTACK_RST;
	logic [COEFF_W-1:0] cfg_release = RELEASE_RST;
	logic [ENV_W-1:0]   env_level   = '0;

	logic [ENV_W-1:0] pending_env[$];
	logic [ENV_W-1:0] env_want;
	int               mismatches     = 0;
	int               send_idle_pct  = 0;
	int               recv_stall_pct = 0;
	int               hold_left      = 0;

	int idle_send[4] = '{0, 67, 0, 35};
	int idle_recv[4] = '{0, 0, 67, 35};

	stim_row_t directed[24] = '{
		'{0, MODE_ABS, '0, '0, 16'sd0, 1, 31'd0},
		'{0, MODE_ABS, '0, '0, 16'sh7FFF, 0, '0},
		'{0, MODE_ABS, '0, '0, 16'sh8000, 0, '0},
		'{0, MODE_ABS, '0, '0, -16'sd1, 0, '0},
		'{0, MODE_ABS, '0, '0, 16'sd1, 0, '0},
		'{1, MODE_ABS, '0, '0, 16'sh8000, 1, 31'h4000_0000},
		'{0, MODE_ABS, '0, '0, 16'sh7FFF, 1, 31'd1073709056},
		'{0, MODE_ABS, '0, '0, 16'sd0, 1, 31'd0},
		'{0, MODE_ABS, '0, '0, -16'sd1, 1, 31'd32768},
		'{0, MODE_ABS, '0, '0, 16'sd1, 1, 31'd32768},
		'{1, MODE_PWR, '0, '0, 16'sh8000, 1, 31'h4000_0000},
		'{0, MODE_PWR, '0, '0, 16'sh7FFF, 1, 31'd1073676289},
		'{0, MODE_PWR, '0, '0, -16'sd1, 1, 31'd1},
		'{1, MODE_RMS, '0, '0, 16'sh8000, 1, 31'h4000_0000},
		'{0, MODE_RMS, '0, '0, 16'sd1, 1, 31'd32768},
		'{0, MODE_RMS, '0, '0, -16'sd1, 1, 31'd32768},
		'{0, MODE_RMS, '0, '0, 16'sh7FFF, 1, 31'd1073709056},
		'{0, MODE_RMS, '0, '0, 16'sd0, 1, 31'd0},
		'{1, MODE_SPARE, '0, '0, -16'sd2, 1, 31'd4},
		'{1, MODE_RMS, '0, 16'd32768, 16'sd100, 1, 31'd3276800},
		'{0, MODE_RMS, '0, 16'd32768, -16'sd100, 1, 31'd3276800},
		'{1, MODE_ABS, 16'hFFFF, 16'hFFFF, 16'sh7FFF, 0, '0},
		'{0, MODE_ABS, 16'hFFFF, 16'hFFFF, 16'sh8000, 0, '0},
		'{1, MODE_PWR, ATTACK_RST, RELEASE_RST, 16'sd0, 0, '0}
	};

	function automatic logic [31:0] root_floor(input logic [63:0] v);
		logic [31:0] r;
		r = '0;
		for (int b = 31; b >= 0; b--) begin
			r[b] = 1'b1;
			if (64'(r) * 64'(r) > v) r[b] = 1'b0;
		end
		return r;
	endfunction

	function automatic logic [ENV_W-1:0] follow_envelope(input logic signed [SAMPLE_W-1:0] smp);
		logic [MAG_W-1:0]   mag;
		logic [63:0]        lvl;
		logic [63:0]        acc;
		logic [COEFF_W-1:0] coef;
		logic [31:0]        root;
		mag = smp[SAMPLE_W-1] ? 17'h10000 - {1'b0, smp} : {1'b0, smp};
		lvl = (cfg_mode == MODE_ABS) ? 64'(mag) << FRAC_SHIFT : 64'(mag) * 64'(mag);
		coef = (64'(env_level) < lvl) ? cfg_attack : cfg_release;
		acc = ((64'd65536 - 64'(coef)) * lvl + 64'(coef) * 64'(env_level)) >> 16;
		env_level = acc[ENV_W-1:0];
		if (cfg_mode != MODE_RMS) return env_level;
		root = root_floor(64'(env_level) << 30);
		return root[ENV_W-1:0];
	endfunction

	function automatic logic [COEFF_W-1:0] pick_coeff();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return 16'($urandom);
			default: return 16'($urandom_range(60000, 65535));
		endcase
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_sample(input bit loud);
		logic [SAMPLE_W-1:0] r;
		r = 16'($urandom);
		case ($urandom_range(0, 9))
			0: r = 16'h8000;
			1: r = 16'h7FFF;
			2: r = {SAMPLE_W{r[0]}};
			3, 4: r = {{8{r[15]}}, r[7:0]};
			default: begin
				if (!loud) r = {{10{r[15]}}, r[5:0]};
			end
		endcase
		return r;
	endfunction

	task automatic drain();
		sample_ch.valid <= 1'b0;
		while (pending_env.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic reg_access(input logic [1:0] idx, input bit wr, input logic [DATA_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= wr ? val : '0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (!wr && prdata !== val) begin
			$error("prdata[%0d]: expected %0d, got %0d", idx, val, prdata);
			mismatches++;
		end
		@(negedge clk);
	endtask

	task automatic configure(input logic [MODE_W-1:0] mode, input logic [COEFF_W-1:0] att,
			input logic [COEFF_W-1:0] rel);
		drain();
		reg_access(REG_MODE, 1'b1, 32'(mode));
		reg_access(REG_ATTACK, 1'b1, 32'(att));
		reg_access(REG_RELEASE, 1'b1, 32'(rel));
		reg_access(REG_MODE, 1'b0, 32'(mode));
		reg_access(REG_ATTACK, 1'b0, 32'(att));
		reg_access(REG_RELEASE, 1'b0, 32'(rel));
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		cfg_mode    = mode;
		cfg_attack  = att;
		cfg_release = rel;
		@(negedge clk);
	endtask

	task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp, input bit known,
			input logic [ENV_W-1:0] typed);
		logic [ENV_W-1:0] pred;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(negedge clk);
		end
		sample_ch.valid     <= 1'b1;
		sample_ch.sample_in <= smp;
		do @(posedge clk); while (!sample_ch.ready);
		pred = follow_envelope(smp);
		pending_env.push_back(known ? typed : pred);
		@(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("tb failed");
		$finish;
	end

	initial begin
		env_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				env_ch.ready <= 1'b0;
			end else begin
				env_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && env_ch.valid && env_ch.ready) begin
			if (pending_env.size() == 0) begin
				$error("envelope_out: expected none, got %0d", env_ch.envelope_out);
				mismatches++;
			end else begin
				env_want = pending_env.pop_front();
				if (env_ch.envelope_out !== env_want) begin
					$error("envelope_out: expected %0d, got %0d", env_want, env_ch.envelope_out);
					mismatches++;
				end
			end
		end
	end

	initial begin
		bit loud;
		loud                = 1'b0;
		arst_n              = 1'b0;
		psel                = 1'b0;
		penable             = 1'b0;
		pwrite              = 1'b0;
		paddr               = '0;
		pwdata              = '0;
		sample_ch.valid     = 1'b0;
		sample_ch.sample_in = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed[i]) begin
			if (directed[i].set) configure(directed[i].mode, directed[i].att, directed[i].rel);
			send_sample(directed[i].smp, directed[i].known, directed[i].env);
		end

		for (int ph = 0; ph < 8; ph++) begin
			configure(2'(ph % 4), pick_coeff(), pick_coeff());
			send_idle_pct  = idle_send[ph % 4];
			recv_stall_pct = idle_recv[ph % 4];
			// hold the receiver off so the input backs up
			if (ph == 4) hold_left = 400;
			for (int n = 0; n < 78; n++) begin
				if (n % 16 == 0) loud = $urandom_range(0, 1);
				if (ph == 5 && n == 39) drain();
				send_sample(pick_sample(loud), 1'b0, '0);
			end
		end

		send_idle_pct  = 0;
		recv_stall_pct = 0;
		drain();
		if (mismatches == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule
